@@ rtl/cdd_pkg.sv @@
// cdd_pkg: shared types, age unit codes and calendar helpers for the
// calendar date difference pipeline. no dependencies.
package cdd_pkg;

    localparam int IN_W  = 80;   // 76 payload bits, padded to whole bytes
    localparam int OUT_W = 56;   // 53 payload bits, padded to whole bytes

    // age unit codes
    localparam logic [2:0] AGE_DECADES = 3'd0;
    localparam logic [2:0] AGE_YEARS   = 3'd1;
    localparam logic [2:0] AGE_MONTHS  = 3'd2;
    localparam logic [2:0] AGE_DAYS    = 3'd3;
    localparam logic [2:0] AGE_HOURS   = 3'd4;
    localparam logic [2:0] AGE_ZERO    = 3'd5;

    // reciprocals for constant division: y / 100 and y / 10 on 12-bit values
    localparam logic [12:0] RECIP100 = 13'd5243;  // ceil(2^19 / 100)
    localparam int          SH100    = 19;
    localparam logic [11:0] RECIP10  = 12'd3277;  // ceil(2^15 / 10)
    localparam int          SH10     = 15;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_ts;

    typedef struct packed {
        t_ts from_ts;
        t_ts to_ts;
    } t_pair;

    // after the time-of-day borrow chain
    typedef struct packed {
        logic [11:0] from_year;
        logic [3:0]  from_month;
        logic [4:0]  from_day;
        logic [11:0] to_year;
        logic [3:0]  to_month;
        logic [4:0]  to_day;
        logic [5:0]  cent;      // to_year / 100
        logic        borrow;    // borrow out of the hour stage
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } t_time_res;

    // after the date borrow chain
    typedef struct packed {
        logic signed [12:0] years;
        logic [3:0]         months;
        logic signed [6:0]  days;
        logic [4:0]         hours;
        logic [5:0]         minutes;
        logic [5:0]         seconds;
    } t_date_res;

    typedef struct packed {
        logic [2:0]         age_unit;
        logic [8:0]         age_value;
        logic [5:0]         seconds;
        logic [5:0]         minutes;
        logic [4:0]         hours;
        logic signed [6:0]  days;
        logic [3:0]         months;
        logic signed [12:0] years;
    } t_result;

    // stage handshake shared by all stages
    typedef struct packed {
        logic en;       // pipeline advances this cycle
    } t_pipe_ctl;

    // length of the month before the given one, february by leap flag
    function automatic logic [4:0] prev_month_len(input logic [3:0] month,
                                                  input logic leap);
        logic [4:0] len;
        case (month)
            4'd3:    len = leap ? 5'd29 : 5'd28;
            4'd5,
            4'd7,
            4'd10,
            4'd12:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/calendar_date_difference_age_unit.sv @@
// calendar_date_difference_age_unit: top level of the calendar date
// difference pipeline. uses cdd_pkg, cdd_time_stage, cdd_date_stage, cdd_age_stage.
//
//  channel  | dir | signals                               | beat
//  ---------+-----+---------------------------------------+---------------------------
//  s_axis   | in  | s_axis_tvalid/tready/tdata[79:0]      | one start/end timestamp pair
//  m_axis   | out | m_axis_tvalid/tready/tdata[55:0]      | one difference with age
//
//  one beat per cycle sustained while m_axis takes every beat, each beat passing
//  through the three register stages (time borrow, date borrow, age)
//  reset (i_rst_n low, synchronous) clears the stage valid bits only
//  a stall on m_axis freezes all stages at once; s_axis_tready drops only
//  while the output register holds a beat that is not taken
module calendar_date_difference_age_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // from_year, from_month, from_day, from_hour, from_minute, from_second,
    // to_year, to_month, to_day, to_hour, to_minute, to_second, 4 zero bits
    input  logic [cdd_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // diff_years, diff_months, diff_days, diff_hours, diff_minutes,
    // diff_seconds, age_value, age_unit, 3 zero bits
    output logic [cdd_pkg::OUT_W-1:0] m_axis_tdata
);
    import cdd_pkg::*;

    t_pipe_ctl  ctl;
    t_pair      pair;
    logic       v_time, v_date, v_age;
    t_time_res  time_res;
    t_date_res  date_res;
    t_result    result;

    // the whole pipe moves whenever the output register is free or drained
    assign ctl.en        = !v_age || m_axis_tready;
    assign s_axis_tready = ctl.en;

    // unpack the input beat, lowest field first
    always_comb begin
        pair.from_ts.year   = s_axis_tdata[11:0];
        pair.from_ts.month  = s_axis_tdata[15:12];
        pair.from_ts.day    = s_axis_tdata[20:16];
        pair.from_ts.hour   = s_axis_tdata[25:21];
        pair.from_ts.minute = s_axis_tdata[31:26];
        pair.from_ts.second = s_axis_tdata[37:32];
        pair.to_ts.year     = s_axis_tdata[49:38];
        pair.to_ts.month    = s_axis_tdata[53:50];
        pair.to_ts.day      = s_axis_tdata[58:54];
        pair.to_ts.hour     = s_axis_tdata[63:59];
        pair.to_ts.minute   = s_axis_tdata[69:64];
        pair.to_ts.second   = s_axis_tdata[75:70];
    end

    // stage 1: second, minute, hour borrows and end year / 100
    cdd_time_stage u_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_valid (s_axis_tvalid),
        .i_pair  (pair),
        .o_valid (v_time),
        .o_res   (time_res)
    );

    // stage 2: leap year, previous month length, day/month/year borrows
    cdd_date_stage u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_valid (v_time),
        .i_res   (time_res),
        .o_valid (v_date),
        .o_res   (date_res)
    );

    // stage 3: coarse age, doubles as the output register
    cdd_age_stage u_age (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_valid (v_date),
        .i_res   (date_res),
        .o_valid (v_age),
        .o_res   (result)
    );

    assign m_axis_tvalid = v_age;
    assign m_axis_tdata  = {3'd0,
                            result.age_unit,
                            result.age_value,
                            result.seconds,
                            result.minutes,
                            result.hours,
                            result.days,
                            result.months,
                            result.years};
endmodule

@@ rtl/cdd_time_stage.sv @@
// cdd_time_stage: first pipeline stage, second/minute/hour borrow chain
// and the century quotient of the end year. uses cdd_pkg.
module cdd_time_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cdd_pkg::t_pipe_ctl i_ctl,
    input  logic              i_valid,
    input  cdd_pkg::t_pair    i_pair,
    output logic              o_valid,
    output cdd_pkg::t_time_res o_res
);
    import cdd_pkg::*;

    logic              r_valid;
    t_time_res         r_res;
    t_time_res         n_res;
    logic              b_sec, b_min, b_hr;
    logic [6:0]        sec_w, min_w;
    logic [5:0]        hr_w;
    logic [24:0]       cent_prod;

    always_comb begin
        b_sec = i_pair.from_ts.second > i_pair.to_ts.second;
        sec_w = {1'b0, i_pair.to_ts.second} + (b_sec ? 7'd60 : 7'd0)
              - {1'b0, i_pair.from_ts.second};
        b_min = ({1'b0, i_pair.from_ts.minute} + {6'd0, b_sec})
              > {1'b0, i_pair.to_ts.minute};
        min_w = {1'b0, i_pair.to_ts.minute} + (b_min ? 7'd60 : 7'd0)
              - {1'b0, i_pair.from_ts.minute} - {6'd0, b_sec};
        b_hr  = ({1'b0, i_pair.from_ts.hour} + {5'd0, b_min})
              > {1'b0, i_pair.to_ts.hour};
        hr_w  = {1'b0, i_pair.to_ts.hour} + (b_hr ? 6'd24 : 6'd0)
              - {1'b0, i_pair.from_ts.hour} - {5'd0, b_min};
        cent_prod = i_pair.to_ts.year * RECIP100;

        n_res.from_year  = i_pair.from_ts.year;
        n_res.from_month = i_pair.from_ts.month;
        n_res.from_day   = i_pair.from_ts.day;
        n_res.to_year    = i_pair.to_ts.year;
        n_res.to_month   = i_pair.to_ts.month;
        n_res.to_day     = i_pair.to_ts.day;
        n_res.cent       = cent_prod[SH100+5:SH100];
        n_res.borrow     = b_hr;
        n_res.hours      = hr_w[4:0];
        n_res.minutes    = min_w[5:0];
        n_res.seconds    = sec_w[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

@@ rtl/cdd_date_stage.sv @@
// cdd_date_stage: second pipeline stage, leap year, day/month/year
// borrow chain. uses cdd_pkg.
module cdd_date_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdd_pkg::t_pipe_ctl  i_ctl,
    input  logic               i_valid,
    input  cdd_pkg::t_time_res  i_res,
    output logic               o_valid,
    output cdd_pkg::t_date_res  o_res
);
    import cdd_pkg::*;

    logic        r_valid;
    t_date_res   r_res;
    t_date_res   n_res;
    logic [12:0] cent_x100;
    logic        leap;
    logic [4:0]  len;
    logic        b_day, b_mon;
    logic [6:0]  day_w;
    logic [4:0]  mon_w;
    logic [12:0] year_w;

    always_comb begin
        // y % 100 == 0 when y equals 100 * (y / 100); y % 400 also needs the
        // quotient to be a multiple of four
        cent_x100 = {1'b0, i_res.cent, 6'd0} + {2'b0, i_res.cent, 5'd0}
                  + {5'd0, i_res.cent, 2'd0};
        leap = (i_res.to_year[1:0] == 2'd0)
             && ((cent_x100 != {1'b0, i_res.to_year}) || (i_res.cent[1:0] == 2'd0));
        len  = prev_month_len(i_res.to_month, leap);

        b_day = ({1'b0, i_res.from_day} + {5'd0, i_res.borrow}) > {1'b0, i_res.to_day};
        day_w = {2'b0, i_res.to_day} + (b_day ? {2'b0, len} : 7'd0)
              - {2'b0, i_res.from_day} - {6'd0, i_res.borrow};
        b_mon = ({1'b0, i_res.from_month} + {4'd0, b_day}) > {1'b0, i_res.to_month};
        mon_w = {1'b0, i_res.to_month} + (b_mon ? 5'd12 : 5'd0)
              - {1'b0, i_res.from_month} - {4'd0, b_day};
        year_w = {1'b0, i_res.to_year} - {1'b0, i_res.from_year} - {12'd0, b_mon};

        n_res.years   = signed'(year_w);
        n_res.months  = mon_w[3:0];
        n_res.days    = signed'(day_w);
        n_res.hours   = i_res.hours;
        n_res.minutes = i_res.minutes;
        n_res.seconds = i_res.seconds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

@@ rtl/cdd_age_stage.sv @@
// cdd_age_stage: last pipeline stage and output register, coarse age
// selection with decades by reciprocal multiply. uses cdd_pkg.
module cdd_age_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdd_pkg::t_pipe_ctl  i_ctl,
    input  logic               i_valid,
    input  cdd_pkg::t_date_res  i_res,
    output logic               o_valid,
    output cdd_pkg::t_result    o_res
);
    import cdd_pkg::*;

    logic        r_valid;
    t_result     r_res;
    t_result     n_res;
    logic [23:0] dec_prod;

    always_comb begin
        dec_prod = i_res.years[11:0] * RECIP10;

        n_res.years   = i_res.years;
        n_res.months  = i_res.months;
        n_res.days    = i_res.days;
        n_res.hours   = i_res.hours;
        n_res.minutes = i_res.minutes;
        n_res.seconds = i_res.seconds;

        if (i_res.years >= 13'sd10) begin
            n_res.age_value = dec_prod[SH10+8:SH10];
            n_res.age_unit  = AGE_DECADES;
        end else if (i_res.years > 13'sd0) begin
            n_res.age_value = {5'd0, i_res.years[3:0]};
            n_res.age_unit  = AGE_YEARS;
        end else if (i_res.months != 4'd0) begin
            n_res.age_value = {5'd0, i_res.months};
            n_res.age_unit  = AGE_MONTHS;
        end else if (i_res.days > 7'sd0) begin
            n_res.age_value = {3'd0, i_res.days[5:0]};
            n_res.age_unit  = AGE_DAYS;
        end else if (i_res.hours != 5'd0) begin
            n_res.age_value = {4'd0, i_res.hours};
            n_res.age_unit  = AGE_HOURS;
        end else begin
            n_res.age_value = 9'd0;
            n_res.age_unit  = AGE_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

@@ rtl/cdd_checker.sv @@
// cdd_checker: port-level assertions for the calendar date difference unit,
// bound to the top level. uses cdd_pkg.
module cdd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [cdd_pkg::IN_W-1:0]  s_axis_tdata,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [cdd_pkg::OUT_W-1:0] m_axis_tdata
);
    import cdd_pkg::*;

    // a beat that is not taken holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // input side only stalls behind a waiting output beat
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // decades only for ten or more years
    a_decades: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[52:50] == AGE_DECADES)
        |-> !m_axis_tdata[12] && (m_axis_tdata[11:0] >= 12'd10))
        else $error("decades unit with fewer than ten years");

    // zero age carries a zero value
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[52:50] == AGE_ZERO)
        |-> (m_axis_tdata[49:41] == 9'd0) && (m_axis_tdata[28:24] == 5'd0))
        else $error("zero age with nonzero value or hours");

    // an accepted beat reaches the output when the pipe keeps moving it through the date and age stages
    a_in_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 s_axis_tready [*2] |=> m_axis_tvalid)
        else $error("accepted beat lost");
endmodule

bind calendar_date_difference_age_unit cdd_checker u_cdd_checker (.*);

@@ sim/calendar_date_difference_age_unit_tb.sv @@
// calendar_date_difference_age_unit_tb: self-checking bench for the calendar date
// difference pipeline, directed timestamp pairs then random ones under random idling
// depends on cdd_pkg and calendar_date_difference_age_unit
module calendar_date_difference_age_unit_tb;
    import cdd_pkg::*;

    localparam int RANDOM_PAIRS = 1850;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 8;       // pipeline is 3 deep, leave some margin

    // one broken-down timestamp, as it travels in s_axis_tdata
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_stamp;

    // one difference beat, as it travels in m_axis_tdata
    typedef struct packed {
        logic signed [12:0] years;
        logic [3:0]         months;
        logic signed [6:0]  days;
        logic [4:0]         hours;
        logic [5:0]         minutes;
        logic [5:0]         seconds;
        logic [8:0]         age_value;
        logic [2:0]         age_unit;
    } t_diff;

    typedef struct {
        t_stamp from_ts;
        t_stamp to_ts;
        bit     typed;      // want holds a hand-written expectation
        t_diff  want;
    } t_row;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    t_diff pending_diffs[$];
    t_row  dir_rows[$];
    int    error_count = 0;
    int    cycle_count = 0;
    int    beat_index  = 0;
    int    rx_stall    = 0;
    bit    calm        = 1'b0;     // no new idle stretches on either side while set

    calendar_date_difference_age_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // from fields in the low bits, then to fields, then zero padding
    function automatic logic [IN_W-1:0] pack_pair(input t_stamp f, input t_stamp t);
        return {{(IN_W-76){1'b0}},
                t.second, t.minute, t.hour, t.day, t.month, t.year,
                f.second, f.minute, f.hour, f.day, f.month, f.year};
    endfunction

    function automatic t_diff unpack_diff(input logic [OUT_W-1:0] d);
        t_diff r;
        r.years     = d[12:0];
        r.months    = d[16:13];
        r.days      = d[23:17];
        r.hours     = d[28:24];
        r.minutes   = d[34:29];
        r.seconds   = d[40:35];
        r.age_value = d[49:41];
        r.age_unit  = d[52:50];
        return r;
    endfunction

    // field-wise difference by borrow chain, plus the coarse age
    function automatic t_diff date_diff(input t_stamp f, input t_stamp t);
        t_diff              r;
        int                 b, nb, prev, mlen, yr, dy, dd, sec, mins, hrs, mon;
        bit                 leap;
        logic signed [12:0] yrs13;
        logic signed [6:0]  days7;
        nb   = (int'(f.second) > int'(t.second)) ? 1 : 0;
        sec  = int'(t.second) - int'(f.second) + (nb ? 60 : 0);
        b    = nb;
        nb   = (int'(f.minute) + b > int'(t.minute)) ? 1 : 0;
        mins = int'(t.minute) - int'(f.minute) - b + (nb ? 60 : 0);
        b    = nb;
        nb   = (int'(f.hour) + b > int'(t.hour)) ? 1 : 0;
        hrs  = int'(t.hour) - int'(f.hour) - b + (nb ? 24 : 0);
        b    = nb;
        // day borrow takes the length of the month before the end month
        yr   = int'(t.year);
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        prev = (t.month == 4'd1) ? 12 : int'(t.month) - 1;
        case (prev)
            2:          mlen = leap ? 29 : 28;
            4, 6, 9, 11: mlen = 30;
            default:    mlen = 31;      // also end months outside one to twelve
        endcase
        nb    = (int'(f.day) + b > int'(t.day)) ? 1 : 0;
        days7 = 7'(int'(t.day) - int'(f.day) - b + (nb ? mlen : 0));
        b     = nb;
        nb    = (int'(f.month) + b > int'(t.month)) ? 1 : 0;
        mon   = int'(t.month) - int'(f.month) - b + (nb ? 12 : 0);
        b     = nb;
        yrs13 = 13'(int'(t.year) - int'(f.year) - b);
        dy    = int'(yrs13);
        dd    = int'(days7);
        r.years   = yrs13;
        r.months  = 4'(mon);
        r.days    = days7;
        r.hours   = 5'(hrs);
        r.minutes = 6'(mins);
        r.seconds = 6'(sec);
        // negative years never pick the years unit
        if (dy >= 10) begin
            r.age_value = 9'(dy / 10);
            r.age_unit  = AGE_DECADES;
        end else if (dy > 0) begin
            r.age_value = 9'(dy);
            r.age_unit  = AGE_YEARS;
        end else if (r.months != 4'd0) begin
            r.age_value = {5'd0, r.months};
            r.age_unit  = AGE_MONTHS;
        end else if (dd > 0) begin
            r.age_value = 9'(dd);
            r.age_unit  = AGE_DAYS;
        end else if (r.hours != 5'd0) begin
            r.age_value = {4'd0, r.hours};
            r.age_unit  = AGE_HOURS;
        end else begin
            r.age_value = '0;
            r.age_unit  = AGE_ZERO;
        end
        return r;
    endfunction

    function automatic t_stamp ts(input int y, mo, d, h, mi, s);
        t_stamp st;
        st.year   = 12'(y);
        st.month  = 4'(mo);
        st.day    = 5'(d);
        st.hour   = 5'(h);
        st.minute = 6'(mi);
        st.second = 6'(s);
        return st;
    endfunction

    function automatic t_diff res(input int yrs, mos, days, hrs, mins, secs, av,
                                  input logic [2:0] unit);
        t_diff r;
        r.years     = 13'(yrs);
        r.months    = 4'(mos);
        r.days      = 7'(days);
        r.hours     = 5'(hrs);
        r.minutes   = 6'(mins);
        r.seconds   = 6'(secs);
        r.age_value = 9'(av);
        r.age_unit  = unit;
        return r;
    endfunction

    task automatic add_row(input t_stamp f, input t_stamp t, input bit typed,
                           input t_diff want);
        t_row row;
        row.from_ts = f;
        row.to_ts   = t;
        row.typed   = typed;
        row.want    = want;
        dir_rows.push_back(row);
    endtask

    // a valid-looking timestamp, any day 1..31 in any month
    function automatic t_stamp any_stamp();
        return ts($urandom_range(0, 4095), $urandom_range(1, 12), $urandom_range(1, 31),
                  $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    // every field bit random, out-of-range values included
    function automatic t_stamp raw_stamp();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[37:0];
    endfunction

    // mostly short idle stretches, a few long ones
    function automatic int idle_len();
        return ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 99) < 60)
            return 0;
        return idle_len();
    endfunction

    task automatic draw_pair(output t_stamp f, output t_stamp t);
        int r;
        r = $urandom_range(0, 99);
        f = any_stamp();
        t = any_stamp();
        if (r < 30) begin
            // same year, often same month, day and hour so the age falls through
            t.year = f.year;
            if ($urandom_range(0, 1) == 0)
                t.month = f.month;
            if ($urandom_range(0, 2) == 0)
                t.day = f.day;
            if ($urandom_range(0, 3) == 0)
                t.hour = f.hour;
        end else if (r < 60) begin
            t.year = 12'(int'(f.year) + int'($urandom_range(0, 13)) - 1);
        end else if (r < 68) begin
            // march end date in a century year, february borrow under the 100/400 rule
            t.year  = 12'(100 * $urandom_range(0, 40));
            t.month = 4'd3;
        end else if (r >= 85) begin
            f = raw_stamp();
            t = raw_stamp();
        end
    endtask

    task automatic report_error(input string msg);
        $display("error: %s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("beat %0d %s: got %0d, expected %0d",
                                   beat_index, name, got, want));
    endtask

    // one beat on s_axis, expectation queued at acceptance
    task automatic send_pair(input t_stamp f, input t_stamp t, input bit typed,
                             input t_diff want, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_pair(f, t);
        do @(posedge i_clk); while (!s_axis_tready);
        pending_diffs.push_back(typed ? want : date_diff(f, t));
    endtask

    // result side: check accepted beats, then pick tready for the next cycle
    always @(posedge i_clk) begin : rx_side
        t_diff got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beat_index++;
            if (pending_diffs.size() == 0) begin
                report_error($sformatf("beat %0d arrived with nothing expected", beat_index));
            end else begin
                want = pending_diffs.pop_front();
                if ($isunknown(m_axis_tdata)) begin
                    report_error($sformatf("beat %0d carries unknown bits", beat_index));
                end else begin
                    got = unpack_diff(m_axis_tdata);
                    check_field("diff_years", int'(got.years), int'(want.years));
                    check_field("diff_months", int'(got.months), int'(want.months));
                    check_field("diff_days", int'(got.days), int'(want.days));
                    check_field("diff_hours", int'(got.hours), int'(want.hours));
                    check_field("diff_minutes", int'(got.minutes), int'(want.minutes));
                    check_field("diff_seconds", int'(got.seconds), int'(want.seconds));
                    check_field("age_value", int'(got.age_value), int'(want.age_value));
                    check_field("age_unit", int'(got.age_unit), int'(want.age_unit));
                end
            end
        end
        if (i_rst_n && !calm && rx_stall == 0 && $urandom_range(0, 99) < 15)
            rx_stall = idle_len();
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("calendar_date_difference_age_unit_tb failed");
            $finish;
        end
    end

    initial begin
        t_stamp f, t;
        t_diff  none;
        none = '0;

        // equal stamps, both extremes, single-unit steps, exactly ten years
        add_row(ts(2000, 1, 1, 0, 0, 0), ts(2000, 1, 1, 0, 0, 0), 1,
                res(0, 0, 0, 0, 0, 0, 0, AGE_ZERO));
        add_row(ts(0, 1, 1, 0, 0, 0), ts(4095, 12, 31, 23, 59, 59), 1,
                res(4095, 11, 30, 23, 59, 59, 409, AGE_DECADES));
        add_row(ts(4095, 12, 31, 23, 59, 59), ts(0, 1, 1, 0, 0, 0), 1,
                res(-4096, 0, 0, 0, 0, 1, 0, AGE_ZERO));
        add_row(ts(2000, 1, 1, 0, 0, 0), ts(2000, 1, 1, 0, 0, 1), 1,
                res(0, 0, 0, 0, 0, 1, 0, AGE_ZERO));
        add_row(ts(2000, 1, 1, 0, 0, 0), ts(2000, 1, 1, 1, 0, 0), 1,
                res(0, 0, 0, 1, 0, 0, 1, AGE_HOURS));
        add_row(ts(2000, 1, 1, 0, 0, 0), ts(2010, 1, 1, 0, 0, 0), 1,
                res(10, 0, 0, 0, 0, 0, 1, AGE_DECADES));
        // years unit, february borrow in leap, century and plain years
        add_row(ts(2000, 1, 1, 0, 0, 0), ts(2009, 6, 1, 0, 0, 0), 0, none);
        add_row(ts(2000, 2, 29, 0, 0, 0), ts(2000, 3, 1, 0, 0, 0), 0, none);
        add_row(ts(1900, 2, 28, 12, 0, 0), ts(1900, 3, 1, 0, 0, 0), 0, none);
        add_row(ts(2024, 2, 28, 0, 0, 0), ts(2024, 3, 1, 0, 0, 0), 0, none);
        add_row(ts(2023, 2, 28, 0, 0, 0), ts(2023, 3, 1, 0, 0, 0), 0, none);
        // negative years fall through to months, then days
        add_row(ts(2001, 1, 15, 0, 0, 0), ts(2000, 6, 15, 0, 0, 0), 0, none);
        add_row(ts(2001, 1, 1, 0, 0, 0), ts(2000, 1, 5, 0, 0, 0), 0, none);
        // end month outside one to twelve, day zero
        add_row(ts(2000, 5, 20, 0, 0, 0), ts(2000, 0, 5, 0, 0, 0), 0, none);
        add_row(ts(2000, 5, 20, 0, 0, 0), ts(2000, 13, 5, 0, 0, 0), 0, none);
        add_row(ts(2000, 15, 20, 10, 0, 0), ts(2001, 15, 5, 9, 0, 0), 0, none);
        add_row(ts(2000, 3, 31, 0, 0, 0), ts(2000, 4, 0, 0, 0, 0), 0, none);
        // time fields beyond their range on either side
        add_row(ts(2000, 1, 1, 0, 0, 0), ts(2000, 1, 1, 31, 63, 63), 0, none);
        add_row(ts(2000, 1, 1, 31, 63, 63), ts(2000, 1, 1, 0, 0, 0), 0, none);
        add_row(ts(4095, 15, 31, 31, 63, 63), ts(0, 0, 0, 0, 0, 0), 0, none);
        add_row(ts(0, 0, 0, 0, 0, 0), ts(4095, 15, 31, 31, 63, 63), 0, none);
        // negative day difference, plain days, borrows rippling all the way up
        add_row(ts(2000, 2, 31, 0, 0, 0), ts(2001, 3, 1, 0, 0, 0), 0, none);
        add_row(ts(2000, 1, 1, 0, 0, 0), ts(2000, 1, 20, 0, 0, 0), 0, none);
        add_row(ts(2000, 1, 31, 23, 59, 59), ts(2000, 2, 1, 0, 0, 0), 0, none);
        add_row(ts(2000, 12, 31, 23, 59, 59), ts(2001, 1, 1, 0, 0, 0), 0, none);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_pair(dir_rows[i].from_ts, dir_rows[i].to_ts, dir_rows[i].typed,
                      dir_rows[i].want, pick_gap());

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            // switch between idling and back-to-back stretches now and then
            if (n % 150 == 0)
                calm = ($urandom_range(0, 2) == 0);
            draw_pair(f, t);
            send_pair(f, t, 1'b0, none, pick_gap());
        end
        s_axis_tvalid <= 1'b0;

        while (pending_diffs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("calendar_date_difference_age_unit_tb passed");
        else
            $display("calendar_date_difference_age_unit_tb failed");
        $finish;
    end

endmodule
